// File: rtl/core/rmsd_pkg.sv
// Shared types, constants and helpers for the multistate RLE pattern decoder.
// Used by rmsd_classify, rmsd_core and multistate_rle_pattern_decoder.
`timescale 1ns / 1ps

package rmsd_pkg;

   // Run count accumulator width; counts saturate at 2^COUNT_BITS - 1
   localparam int COUNT_BITS = 16;
   // Width of run lengths, row lengths and row totals on the result beat
   localparam int OUT_BITS   = 16;
   localparam int WIDE_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
   localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

   localparam int CHAR_BITS  = 8;
   localparam int STATE_BITS = 9;

   // Character codes
   localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_BANG   = 8'h21;
   localparam logic [CHAR_BITS-1:0] CH_DOLLAR = 8'h24;
   localparam logic [CHAR_BITS-1:0] CH_DOT    = 8'h2E;
   localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_B = 8'h62;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_O = 8'h6F;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_P = 8'h70;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_Y = 8'h79;

   // Cell state numbering
   localparam logic [STATE_BITS-1:0] STATE_DEAD      = 9'd0;
   localparam logic [STATE_BITS-1:0] STATE_ALIVE     = 9'd255;
   localparam logic [STATE_BITS-1:0] STATE_EXT_BASE  = 9'd25;
   localparam logic [STATE_BITS-1:0] STATE_EXT_SPAN  = 9'd24;

   // Result beat kinds
   typedef enum logic [1:0] {
      KIND_RUN     = 2'd0,
      KIND_ROW_END = 2'd1,
      KIND_PAT_END = 2'd2
   } item_kind_type;

   // Character classes
   typedef enum logic [2:0] {
      CLS_IGNORE,
      CLS_DIGIT,
      CLS_ROW_END,
      CLS_PAT_END,
      CLS_PREFIX,
      CLS_LETTER,
      CLS_ALIVE,
      CLS_DEAD
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;   // value of a decimal digit
      logic [4:0]     letter;  // 'A'..'X' as 0..23
      logic [3:0]     prefix;  // 'p'..'y' as 0..9
   } char_info_type;

   typedef struct packed {
      logic                  valid;
      item_kind_type         kind;
      logic [STATE_BITS-1:0] cell_state;
      logic [OUT_BITS-1:0]   run_length;
      logic [OUT_BITS-1:0]   widest_row;
      logic [OUT_BITS-1:0]   row_total;
   } result_type;

   // Turn the accumulated count into a run length: zero means one, clamp to OUT_MAX
   function automatic logic [OUT_BITS-1:0] take_count(input logic [COUNT_BITS-1:0] c);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(c);
      if (w == '0) begin
         return OUT_BITS'(1);
      end
      if (w > WIDE_BITS'(OUT_MAX)) begin
         return OUT_MAX;
      end
      return OUT_BITS'(w);
   endfunction

   // Saturating add on result-width counters
   function automatic logic [OUT_BITS-1:0] sat_add(input logic [OUT_BITS-1:0] a,
                                                   input logic [OUT_BITS-1:0] b);
      logic [OUT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[OUT_BITS]) begin
         return OUT_MAX;
      end
      return s[OUT_BITS-1:0];
   endfunction

endpackage

// File: rtl/core/rmsd_classify.sv
// Character classifier: maps one pattern byte to its class and small operand values.
// Depends on rmsd_pkg.
`timescale 1ns / 1ps

module rmsd_classify (
   input  logic [rmsd_pkg::CHAR_BITS-1:0] char_code,
   output rmsd_pkg::char_info_type        info
);
   import rmsd_pkg::*;

   // Pick the class; operand fields are meaningful only for their own class
   always_comb begin
      info.digit  = 4'(char_code - CH_ZERO);
      info.letter = 5'(char_code - CH_UPPER_A);
      info.prefix = 4'(char_code - CH_LOWER_P);
      priority if (char_code == CH_NUL || char_code == CH_BANG) begin
         info.cls = CLS_PAT_END;
      end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
         info.cls = CLS_DIGIT;
      end else if (char_code == CH_DOLLAR) begin
         info.cls = CLS_ROW_END;
      end else if (char_code >= CH_LOWER_P && char_code <= CH_LOWER_Y) begin
         info.cls = CLS_PREFIX;
      end else if (char_code == CH_LOWER_O) begin
         info.cls = CLS_ALIVE;
      end else if (char_code == CH_LOWER_B || char_code == CH_DOT) begin
         info.cls = CLS_DEAD;
      end else if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_X) begin
         info.cls = CLS_LETTER;
      end else begin
         info.cls = CLS_IGNORE;
      end
   end

endmodule

// File: rtl/core/rmsd_core.sv
// Decoder state and per-character update: run count, prefix, row lengths, row total.
// Produces at most one result beat per step. Depends on rmsd_pkg.
`timescale 1ns / 1ps

module rmsd_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  rmsd_pkg::char_info_type info,
   output rmsd_pkg::result_type    result,
   output logic                    done
);
   import rmsd_pkg::*;

   logic [COUNT_BITS-1:0] count_accum_ff, count_accum_in;
   logic                  prefix_pending_ff, prefix_pending_in;
   logic [3:0]            prefix_digit_ff, prefix_digit_in;
   logic [OUT_BITS-1:0]   current_row_len_ff, current_row_len_in;
   logic [OUT_BITS-1:0]   max_row_len_ff, max_row_len_in;
   logic [OUT_BITS-1:0]   rows_seen_ff, rows_seen_in;
   logic                  finished_ff, finished_in;

   logic [OUT_BITS-1:0]     run_n;
   logic [OUT_BITS-1:0]     row_after_run;
   logic [OUT_BITS-1:0]     widest_now;
   logic [COUNT_BITS+3:0]   count_times_ten;
   logic [COUNT_BITS-1:0]   count_next_digit;
   logic [STATE_BITS-1:0]   ext_state;
   logic [STATE_BITS-1:0]   run_state;
   logic                    do_run;

   // Shared terms
   assign run_n         = take_count(count_accum_ff);
   assign row_after_run = sat_add(current_row_len_ff, run_n);
   assign widest_now    = (current_row_len_ff > max_row_len_ff) ? current_row_len_ff
                                                                : max_row_len_ff;
   assign count_times_ten = ({4'b0, count_accum_ff} << 3) + ({4'b0, count_accum_ff} << 1)
                          + (COUNT_BITS+4)'(info.digit);
   assign count_next_digit = (count_times_ten > (COUNT_BITS+4)'({COUNT_BITS{1'b1}}))
                           ? {COUNT_BITS{1'b1}} : count_times_ten[COUNT_BITS-1:0];
   assign ext_state = STATE_EXT_BASE + STATE_EXT_SPAN * STATE_BITS'(prefix_digit_ff)
                    + STATE_BITS'(info.letter);

   // Next state and result for the character in hand
   always_comb begin
      count_accum_in     = count_accum_ff;
      prefix_pending_in  = 1'b0;
      prefix_digit_in    = '0;
      current_row_len_in = current_row_len_ff;
      max_row_len_in     = max_row_len_ff;
      rows_seen_in       = rows_seen_ff;
      finished_in        = finished_ff;
      do_run             = 1'b0;
      run_state          = STATE_DEAD;
      result.valid       = 1'b0;
      result.kind        = KIND_RUN;
      result.cell_state  = STATE_DEAD;
      result.run_length  = run_n;
      result.widest_row  = max_row_len_ff;
      result.row_total   = rows_seen_ff;

      priority if (finished_ff) begin
         prefix_pending_in = prefix_pending_ff;
         prefix_digit_in   = prefix_digit_ff;
      end else if (prefix_pending_ff && info.cls == CLS_LETTER) begin
         do_run    = 1'b1;
         run_state = ext_state;
      end else begin
         unique case (info.cls)
            CLS_PAT_END: begin
               count_accum_in    = '0;
               max_row_len_in    = widest_now;
               finished_in       = 1'b1;
               result.valid      = 1'b1;
               result.kind       = KIND_PAT_END;
               result.run_length = OUT_BITS'(1);
               result.widest_row = widest_now;
            end
            CLS_DIGIT: begin
               count_accum_in = count_next_digit;
            end
            CLS_ROW_END: begin
               count_accum_in     = '0;
               max_row_len_in     = widest_now;
               current_row_len_in = '0;
               rows_seen_in       = sat_add(rows_seen_ff, run_n);
               result.valid       = 1'b1;
               result.kind        = KIND_ROW_END;
               result.widest_row  = widest_now;
               result.row_total   = sat_add(rows_seen_ff, run_n);
            end
            CLS_PREFIX: begin
               prefix_pending_in = 1'b1;
               prefix_digit_in   = info.prefix;
            end
            CLS_ALIVE: begin
               do_run    = 1'b1;
               run_state = STATE_ALIVE;
            end
            CLS_DEAD: begin
               do_run    = 1'b1;
               run_state = STATE_DEAD;
            end
            CLS_LETTER: begin
               do_run    = 1'b1;
               run_state = STATE_BITS'(info.letter) + STATE_BITS'(1);
            end
            CLS_IGNORE: begin
            end
            default: begin
            end
         endcase
      end

      // Cell run: consume count, grow the row, track the widest row
      if (do_run) begin
         count_accum_in     = '0;
         current_row_len_in = row_after_run;
         if (row_after_run > max_row_len_ff) begin
            max_row_len_in = row_after_run;
         end
         result.valid      = 1'b1;
         result.kind       = KIND_RUN;
         result.cell_state = run_state;
         result.widest_row = (row_after_run > max_row_len_ff) ? row_after_run
                                                              : max_row_len_ff;
      end
   end

   // State registers advance only on a step
   always_ff @(posedge clock) begin
      if (reset) begin
         count_accum_ff     <= '0;
         prefix_pending_ff  <= 1'b0;
         prefix_digit_ff    <= '0;
         current_row_len_ff <= '0;
         max_row_len_ff     <= '0;
         rows_seen_ff       <= OUT_BITS'(1);
         finished_ff        <= 1'b0;
      end else if (step) begin
         count_accum_ff     <= count_accum_in;
         prefix_pending_ff  <= prefix_pending_in;
         prefix_digit_ff    <= prefix_digit_in;
         current_row_len_ff <= current_row_len_in;
         max_row_len_ff     <= max_row_len_in;
         rows_seen_ff       <= rows_seen_in;
         finished_ff        <= finished_in;
      end
   end

   assign done = finished_ff;

endmodule

// File: rtl/core/multistate_rle_pattern_decoder.sv
// Multistate RLE pattern decoder, top level: input register, decode, result register.
// Each character beat is held in the input register; its result beat, if any, is captured in the result register.
// Throughput: one character per cycle; a stalled result register holds the pipe.
// Reset (synchronous, active high) empties both registers and restores decoder state.
// Depends on rmsd_pkg, rmsd_classify and rmsd_core.
`timescale 1ns / 1ps

module multistate_rle_pattern_decoder (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] char_code
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [8:0] cell_state, [24:9] run_length, [40:25] widest_row,
   //            [56:41] row_total, [63:57] zero
   // rsp_tuser: [1:0] item_kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   output logic [1:0]  rsp_tuser
);
   import rmsd_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [CHAR_BITS-1:0] in_char_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff;
   logic                 step;
   logic                 done;
   char_info_type        info;
   result_type           result;

   // Process the held character when the result register can take a beat
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   rmsd_classify u_classify (
      .char_code (in_char_ff),
      .info      (info)
   );

   rmsd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .info   (info),
      .result (result),
      .done   (done)
   );

   // Input register control
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register control
   always_comb begin
      out_valid_in = out_valid_ff;
      if (step && result.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
      end
      if (step && result.valid) begin
         out_ff <= result;
      end
   end

   // Drive the result beat
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {7'b0, out_ff.row_total, out_ff.widest_row,
                        out_ff.run_length, out_ff.cell_state};

   // A held result beat is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !step)
      else $error("result register overwritten while stalled");

   // Nothing comes out of the decoder once the pattern has ended
   assert property (@(posedge clock) disable iff (reset)
      done |-> !result.valid)
      else $error("result produced after pattern end");

   // Every result beat carries a nonzero run length and row total
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_ff.run_length != '0 && out_ff.row_total != '0))
      else $error("zero run length or row total on result beat");

   // Only cell runs carry a cell state
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.kind != KIND_RUN) |-> (out_ff.cell_state == STATE_DEAD))
      else $error("cell state on row end or pattern end beat");

endmodule
